// ----- hw/rtl/u8s_pkg.sv -----
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types and constants for the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

	localparam logic [7:0] REP_RESET  = 8'h5F;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] ASCII_HI   = 8'h7F;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [7:0] CONT_LO    = 8'h80;
	localparam logic [7:0] CONT_HI    = 8'hBF;
	localparam logic [7:0] E0_CONT_LO = 8'hA0;
	localparam logic [7:0] F0_CONT_LO = 8'h90;
	localparam logic [7:0] F4_CONT_HI = 8'h8F;

	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic       eot;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic       last;
		logic       rep;
		logic [7:0] data;
	} out_item_t;

endpackage

// ----- hw/rtl/utf8_stream_sanitizer.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Cleans a UTF-8 byte stream: drops zeros, folds CR/CRLF to LF, passes
// well-formed sequences and substitutes a replacement byte for stray bytes.
// ----------------------------------------------------------------------------
// Flow: each byte is taken into the hold buffer, then each held byte is
// examined or emitted, and then the item is closed; no new byte is taken
// until the last one is closed. The hold engine handles one byte decision
// per cycle while the output queue accepts it; the input and output queues
// let the upstream and downstream sides stall independently of it. The last
// result of each input byte carries tlast; a byte that yields nothing (zero,
// the LF of a CRLF, a held lead) produces no transfer. The replacement byte
// register resets to underscore and is written through cfg_*; the user is to
// write it only while idle, which the block itself leaves to the user.
module utf8_stream_sanitizer import u8s_pkg::*; #(
	parameter int IN_DEPTH  = IN_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,       // replacement_byte
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // end_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] is_replacement
	output logic       m_axis_tlast    // last_of_run
);

	logic [7:0] rep_q;
	in_item_t   s_item, q_item;
	out_item_t  e_item, m_item;
	logic       q_valid, q_ready, e_valid, e_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= REP_RESET;
		end else if (cfg_valid) begin
			rep_q <= cfg_data;
		end
	end

	assign s_item.data = s_axis_tdata;
	assign s_item.eot  = s_axis_tlast;

	u8s_fifo #(
		.WIDTH ($bits(in_item_t)),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_axis_tvalid),
		.wr_ready (s_axis_tready),
		.wr_data  (s_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_item)
	);

	u8s_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.rep_byte  (rep_q),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (e_valid),
		.out_ready (e_ready),
		.out_item  (e_item)
	);

	u8s_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (e_valid),
		.wr_ready (e_ready),
		.wr_data  (e_item),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (m_item)
	);

	assign m_axis_tdata = m_item.data;
	assign m_axis_tuser = m_item.rep;
	assign m_axis_tlast = m_item.last;

endmodule

// ----- hw/rtl/u8s_fifo.sv -----
// ----------------------------------------------------------------------------
// u8s_fifo
// Small register queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module u8s_fifo import u8s_pkg::*; #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign wr_ready = (cnt_q != CNT_FULL);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/u8s_engine.sv -----
// ----------------------------------------------------------------------------
// u8s_engine
// Back end: holds up to four bytes, decides on the oldest one per cycle
// unless stalled and stages emitted bytes so an item's final one has last.
// ----------------------------------------------------------------------------
module u8s_engine import u8s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] rep_byte,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EMIT} state_t;

	state_t     state_q;
	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic       eot_q;
	logic       cr_q;
	logic [1:0] left_q;
	logic       stg_vld_q;
	logic [7:0] stg_byte_q;
	logic       stg_rep_q;

	logic [7:0] b0;
	logic [1:0] need;
	logic [7:0] lo, hi;
	logic       is_lead, have_all, seq_ok;
	logic [2:0] avail;
	logic       close_now, emit_now, shift_now, set_cr, start_seq;
	logic [7:0] emit_byte;
	logic       emit_rep;

	assign b0    = buf_q[0];
	assign avail = cnt_q - 3'd1;

	always_comb begin
		need    = 2'd0;
		lo      = CONT_LO;
		hi      = CONT_HI;
		is_lead = 1'b0;
		if (b0 inside {[LEAD2_LO:LEAD2_HI]}) begin
			need    = 2'd1;
			is_lead = 1'b1;
		end else if (b0 inside {[LEAD3_LO:LEAD3_HI]}) begin
			need    = 2'd2;
			is_lead = 1'b1;
			if (b0 == LEAD3_LO) lo = E0_CONT_LO;
		end else if (b0 inside {[LEAD4_LO:LEAD4_HI]}) begin
			need    = 2'd3;
			is_lead = 1'b1;
			if (b0 == LEAD4_LO) lo = F0_CONT_LO;
			if (b0 == LEAD4_HI) hi = F4_CONT_HI;
		end
	end

	assign have_all = (avail >= {1'b0, need});
	assign seq_ok   = (buf_q[1] >= lo) && (buf_q[1] <= hi)
		&& ((need < 2'd2) || ((buf_q[2] >= CONT_LO) && (buf_q[2] <= CONT_HI)))
		&& ((need < 2'd3) || ((buf_q[3] >= CONT_LO) && (buf_q[3] <= CONT_HI)));

	// one decision per cycle on the oldest held byte while out_ready is high
	always_comb begin
		close_now = 1'b0;
		emit_now  = 1'b0;
		shift_now = 1'b0;
		set_cr    = 1'b0;
		start_seq = 1'b0;
		emit_byte = b0;
		emit_rep  = 1'b0;
		case (state_q)
			ST_SCAN: begin
				if (cnt_q == 3'd0 || (is_lead && !have_all && !eot_q)) begin
					close_now = 1'b1;
				end else if ((cr_q && b0 == CH_LF) || b0 == CH_NUL) begin
					shift_now = 1'b1;
				end else if (b0 <= ASCII_HI) begin
					emit_now  = 1'b1;
					shift_now = 1'b1;
					if (b0 == CH_CR) begin
						emit_byte = CH_LF;
						set_cr    = 1'b1;
					end
				end else if (!is_lead || !have_all) begin
					emit_now  = 1'b1;
					shift_now = 1'b1;
					emit_byte = rep_byte;
					emit_rep  = 1'b1;
				end else if (seq_ok) begin
					emit_now  = 1'b1;
					shift_now = 1'b1;
					start_seq = 1'b1;
				end else begin
					// bad continuation: lead dropped, rest re-examined
					shift_now = 1'b1;
				end
			end
			ST_EMIT: begin
				emit_now  = 1'b1;
				shift_now = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_ready       = (state_q == ST_LOAD);
	assign out_valid      = stg_vld_q && (close_now || emit_now);
	assign out_item.data  = stg_byte_q;
	assign out_item.rep   = stg_rep_q;
	assign out_item.last  = close_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= 3'd0;
			eot_q     <= 1'b0;
			cr_q      <= 1'b0;
			left_q    <= 2'd0;
			stg_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						cnt_q   <= cnt_q + 3'd1;
						eot_q   <= in_item.eot;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (out_ready) begin
						if (close_now) begin
							if (cnt_q != 3'd0 || eot_q) cr_q <= 1'b0;
							stg_vld_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							cr_q <= set_cr;
							if (emit_now) stg_vld_q <= 1'b1;
							if (shift_now) cnt_q <= cnt_q - 3'd1;
							if (start_seq) begin
								left_q  <= need;
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						stg_vld_q <= 1'b1;
						cnt_q     <= cnt_q - 3'd1;
						left_q    <= left_q - 2'd1;
						if (left_q == 2'd1) state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid) begin
			buf_q[cnt_q[1:0]] <= in_item.data;
		end else if (out_ready && shift_now) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
		if (out_ready && emit_now) begin
			stg_byte_q <= emit_byte;
			stg_rep_q  <= emit_rep;
		end
	end

endmodule

// ----- hw/rtl/u8s_checker.sv -----
// ----------------------------------------------------------------------------
// u8s_checker
// Port-level checks for the UTF-8 stream sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
module u8s_checker import u8s_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [7:0] cfg_data,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	logic [7:0] rep_shadow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_shadow_q <= REP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rep_shadow_q <= cfg_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output transfer changed while stalled");

	a_rep_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == rep_shadow_q)
		else $error("replacement flag on a byte other than the replacement");

	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != CH_NUL)
		else $error("zero byte passed through");

	a_no_cr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != CH_CR)
		else $error("CR passed through");

endmodule

bind utf8_stream_sanitizer u8s_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_data      (cfg_data),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
